// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the one-byte extension parser.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTP1B_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define RTP1B_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RTP1B_ASSERT(lbl, prop, msg)
`define RTP1B_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/rtp1b_pkg.sv =====
// Types and constants of the RTP one-byte header extension parser.
// No dependencies; used by rtp1b_out_queue and rtp_one_byte_ext_parser.
package rtp1b_pkg;

  localparam int unsigned MAX_ELEMENT_BYTES = 16;
  localparam int unsigned CFG_ADDR_W        = 3;
  localparam int unsigned CFG_DATA_W        = 32;

  localparam logic [7:0] CAPACITY_RESET = 8'hFF;
  localparam logic [7:0] COUNT_MAX      = 8'hFF;
  localparam logic [3:0] ID_STOP        = 4'hF;
  localparam logic [3:0] ID_NONE        = 4'h0;

  // register index (word address)
  localparam logic [0:0] REG_ELEMENT_CAPACITY = 1'b0;

  localparam logic KIND_ELEMENT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_TRUNCATED = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_STOP   = 2'd2
  } phase_t;

  typedef struct packed {
    logic        result_kind;
    logic [3:0]  element_id;
    logic [4:0]  element_length;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [7:0]  element_count;
    logic        parse_status;
    logic        last_result;
  } result_t;

endpackage

// ===== rtl/core/rtp1b_out_queue.sv =====
// Three-entry shifting result queue; head entry is the output register.
// Takes up to two results per cycle while space_ok is high. Depends on rtp1b_pkg, assert_macros.svh.
`include "assert_macros.svh"

module rtp1b_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_cnt,
  input  rtp1b_pkg::result_t push0,
  input  rtp1b_pkg::result_t push1,
  output logic               space_ok,
  output logic               out_valid,
  input  logic               out_ready,
  output rtp1b_pkg::result_t out_head
);

  rtp1b_pkg::result_t ent_r   [0:2];
  rtp1b_pkg::result_t ent_nxt [0:2];
  rtp1b_pkg::result_t shifted [0:2];
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [1:0] cnt_pop;
  logic       pop;

  assign pop      = (cnt_r != 2'd0) && out_ready;
  assign cnt_pop  = cnt_r - {1'b0, pop};
  assign cnt_nxt  = cnt_pop + push_cnt;
  assign space_ok = (cnt_r <= 2'd1);
  assign out_valid = (cnt_r != 2'd0);
  assign out_head  = ent_r[0];

  always_comb begin
    shifted[0] = pop ? ent_r[1] : ent_r[0];
    shifted[1] = pop ? ent_r[2] : ent_r[1];
    shifted[2] = ent_r[2];
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < cnt_pop) begin
        ent_nxt[i] = shifted[i];
      end else if (2'(i) == cnt_pop) begin
        ent_nxt[i] = push0;
      end else begin
        ent_nxt[i] = push1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  `RTP1B_ASSERT(a_no_push_when_full, space_ok || (push_cnt == 2'd0), "push without space")
  `RTP1B_ASSERT(a_no_overflow, (cnt_pop + push_cnt) >= cnt_pop, "queue count wrapped")
  `RTP1B_ASSERT_NEXT(a_pop_only, pop && (push_cnt == 2'd0), cnt_r == $past(cnt_r) - 2'd1, "pop miscounted")

endmodule

// ===== rtl/core/rtp_one_byte_ext_parser.sv =====
// RTP one-byte header extension body parser, one body byte per beat.
// Latency: with the result queue empty, a result is on the out_ ports the cycle after its
// input beat is accepted.
// Throughput: one beat per cycle while in_ready is high; a beat that yields an element
// and a summary fills two queue entries, so in_ready drops until the extra one is popped.
// Reset: synchronous, active low; parse state and queue cleared, capacity 255.
// Depends on rtp1b_pkg, rtp1b_out_queue and assert_macros.svh.
`include "assert_macros.svh"

module rtp_one_byte_ext_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_byte_present,
  input  logic                                in_body_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_result_kind,
  output logic [3:0]                          out_element_id,
  output logic [4:0]                          out_element_length,
  output logic [63:0]                         out_data_high,
  output logic [63:0]                         out_data_low,
  output logic [7:0]                          out_element_count,
  output logic                                out_parse_status,
  output logic                                out_last_result,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rtp1b_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [rtp1b_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [rtp1b_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);

  rtp1b_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]   rem_r, rem_nxt;
  logic [3:0]   id_r, id_nxt;
  logic [4:0]   len_r, len_nxt;
  logic         keep_r, keep_nxt;
  logic [127:0] buf_r, buf_nxt;
  logic [7:0]   count_r, count_nxt;
  logic [7:0]   cap_r;

  logic         accept;
  logic         space_ok;
  logic         cfg_wr;
  logic [3:0]   hdr_id;
  logic [4:0]   hdr_len;
  logic [3:0]   pos;
  logic [4:0]   rem_dec;
  logic [127:0] buf_wr;
  logic         elem_fire;
  logic [1:0]   push_cnt;
  logic         out_elem;
  logic         id_reserved;
  logic         state_clear;
  rtp1b_pkg::result_t elem_res, sum_res, push0, push1, head;

  assign accept   = in_valid && in_ready;
  assign in_ready = space_ok;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[2] == rtp1b_pkg::REG_ELEMENT_CAPACITY);
  assign cfg_prdata = (cfg_paddr[2] == rtp1b_pkg::REG_ELEMENT_CAPACITY) ?
                      {{(rtp1b_pkg::CFG_DATA_W-8){1'b0}}, cap_r} : '0;

  assign hdr_id  = in_data_byte[7:4];
  assign hdr_len = {1'b0, in_data_byte[3:0]} + 5'd1;
  assign pos     = 4'(len_r - rem_r);
  assign rem_dec = rem_r - 5'd1;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      buf_wr[127-8*k -: 8] = (pos == 4'(k)) ? in_data_byte : buf_r[127-8*k -: 8];
    end
  end

  // parse state machine
  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    keep_nxt  = keep_r;
    buf_nxt   = buf_r;
    count_nxt = count_r;
    elem_fire = 1'b0;
    if (in_byte_present) begin
      case (phase_r)
        rtp1b_pkg::PH_HEADER: begin
          if (in_data_byte != 8'd0) begin
            if (hdr_id == rtp1b_pkg::ID_STOP) begin
              phase_nxt = rtp1b_pkg::PH_STOP;
            end else begin
              id_nxt    = hdr_id;
              len_nxt   = hdr_len;
              rem_nxt   = hdr_len;
              keep_nxt  = (count_r < cap_r) && (hdr_id != rtp1b_pkg::ID_NONE) &&
                          (hdr_len <= 5'(rtp1b_pkg::MAX_ELEMENT_BYTES));
              buf_nxt   = '0;
              phase_nxt = rtp1b_pkg::PH_DATA;
            end
          end
        end
        rtp1b_pkg::PH_DATA: begin
          buf_nxt = buf_wr;
          rem_nxt = rem_dec;
          if (rem_dec == 5'd0) begin
            phase_nxt = rtp1b_pkg::PH_HEADER;
            if (keep_r) begin
              elem_fire = 1'b1;
              if (count_r != rtp1b_pkg::COUNT_MAX) begin
                count_nxt = count_r + 8'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    elem_res.result_kind    = rtp1b_pkg::KIND_ELEMENT;
    elem_res.element_id     = id_r;
    elem_res.element_length = len_r;
    elem_res.data_high      = buf_wr[127:64];
    elem_res.data_low       = buf_wr[63:0];
    elem_res.element_count  = 8'd0;
    elem_res.parse_status   = rtp1b_pkg::STATUS_OK;
    elem_res.last_result    = 1'b0;

    sum_res.result_kind    = rtp1b_pkg::KIND_SUMMARY;
    sum_res.element_id     = 4'd0;
    sum_res.element_length = 5'd0;
    sum_res.data_high      = 64'd0;
    sum_res.data_low       = 64'd0;
    sum_res.element_count  = count_nxt;
    sum_res.parse_status   = (phase_nxt == rtp1b_pkg::PH_DATA) ?
                             rtp1b_pkg::STATUS_TRUNCATED : rtp1b_pkg::STATUS_OK;
    sum_res.last_result    = 1'b1;

    if (in_body_end) begin
      phase_nxt = rtp1b_pkg::PH_HEADER;
      rem_nxt   = 5'd0;
      id_nxt    = 4'd0;
      len_nxt   = 5'd0;
      keep_nxt  = 1'b0;
      buf_nxt   = '0;
      count_nxt = 8'd0;
    end
  end

  assign push0    = elem_fire ? elem_res : sum_res;
  assign push1    = sum_res;
  assign push_cnt = accept ? ({1'b0, elem_fire} + {1'b0, in_body_end}) : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rtp1b_pkg::PH_HEADER;
      rem_r   <= 5'd0;
      id_r    <= 4'd0;
      len_r   <= 5'd0;
      keep_r  <= 1'b0;
      count_r <= 8'd0;
      cap_r   <= rtp1b_pkg::CAPACITY_RESET;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        rem_r   <= rem_nxt;
        id_r    <= id_nxt;
        len_r   <= len_nxt;
        keep_r  <= keep_nxt;
        count_r <= count_nxt;
      end
      if (cfg_wr) begin
        cap_r <= cfg_pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r <= buf_nxt;
    end
  end

  rtp1b_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push0     (push0),
    .push1     (push1),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_head  (head)
  );

  assign out_result_kind    = head.result_kind;
  assign out_element_id     = head.element_id;
  assign out_element_length = head.element_length;
  assign out_data_high      = head.data_high;
  assign out_data_low       = head.data_low;
  assign out_element_count  = head.element_count;
  assign out_parse_status   = head.parse_status;
  assign out_last_result    = head.last_result;

  assign out_elem    = out_valid && (out_result_kind == rtp1b_pkg::KIND_ELEMENT);
  assign id_reserved = (out_element_id == rtp1b_pkg::ID_NONE) ||
                       (out_element_id == rtp1b_pkg::ID_STOP);
  assign state_clear = (phase_r == rtp1b_pkg::PH_HEADER) && (count_r == 8'd0);

  `RTP1B_ASSERT(a_elem_id_valid, !out_elem || !id_reserved, "element with reserved id")
  `RTP1B_ASSERT(a_fire_needs_keep, !elem_fire || keep_r, "element emitted while skipping")
  `RTP1B_ASSERT_NEXT(a_body_end_clears, accept && in_body_end, state_clear, "body not cleared")

endmodule
